### rtl/psd_pkg.sv
`default_nettype none

package psd_pkg;

  // Capture file framing constants
  localparam logic [31:0] MAGIC_NATIVE = 32'ha1b2c3d4;
  localparam int unsigned GLOBAL_LEN   = 24;
  localparam int unsigned PACKET_LEN   = 16;

  // Header bytes held in the shift line (the final byte arrives live)
  localparam int unsigned HDR_DEPTH = GLOBAL_LEN - 1;
  // Position of the first packet header byte inside the shift line
  localparam int unsigned PKT_BASE  = GLOBAL_LEN - PACKET_LEN;

  // Record kinds
  localparam logic [1:0] REC_GLOBAL  = 2'd0;
  localparam logic [1:0] REC_PACKET  = 2'd1;
  localparam logic [1:0] REC_PAYLOAD = 2'd2;

  // Parse phases
  typedef enum logic [1:0] {
    PH_GLOBAL  = 2'd0,
    PH_PACKET  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // One result word
  typedef struct packed {
    logic        swapped;
    logic        last;
    logic [7:0]  payload_byte;
    logic [31:0] word_e;
    logic [31:0] word_d;
    logic [31:0] word_c;
    logic [31:0] word_b;
    logic [31:0] word_a;
    logic [15:0] ver_minor;
    logic [15:0] ver_major;
    logic [1:0]  kind;
  } rec_t;

  // Four header bytes in stream order as a 32-bit field
  function automatic logic [31:0] fld32(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3,
                                        input logic sw);
    logic [31:0] v;
    v = sw ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    return v;
  endfunction

  // Two header bytes in stream order as a 16-bit field
  function automatic logic [15:0] fld16(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic sw);
    logic [15:0] v;
    v = sw ? {b0, b1} : {b1, b0};
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/pcap_stream_deframer.sv
// pcap_stream_deframer: splits a capture-file byte stream into records.
// Input channel in_*: one raw byte per word. Output channel out_*: one
// record per word, its kind in out_tuser: the 24-byte global header once,
// then for each packet a packet header record followed by its payload
// bytes, one per word, with out_tlast on the final byte of a packet.
// A packet whose included length is zero ends with its header record.
// Header bytes that do not complete a header produce no output word.
// A record is registered in the output register (in the skid register on a
// stall) once its last byte is accepted. One byte per cycle while the skid
// is empty; each byte needs a counter update and a shift of the header line.
// The output register is backed by a one-word skid register, so in_tready
// is registered and the block keeps taking a byte while a record waits.
// When the receiver stalls, at most one more record is held in the skid
// register; then in_tready drops until the output drains.
// Reset (rst_n low, synchronous) returns to the global header phase with
// byte order native and no record pending.
`default_nettype none

module pcap_stream_deframer (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input: [7:0] stream_byte
  input  wire logic [7:0]   in_tdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // Output: [15:0] ver_major, [31:16] ver_minor, [63:32] word_a,
  // [95:64] word_b, [127:96] word_c, [159:128] word_d, [191:160] word_e,
  // [199:192] payload_byte
  output logic [199:0]      out_tdata,
  // Output: [1:0] record_kind, [2] byte_order_swapped
  output logic [2:0]        out_tuser,
  output logic              out_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready
);

  psd_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]      count_r, count_nxt;
  logic            swap_r, swap_nxt;
  logic [31:0]     remain_r, remain_nxt;
  logic [7:0]      hdr_r [0:psd_pkg::HDR_DEPTH-1];

  psd_pkg::rec_t   res;
  logic            res_vld;
  psd_pkg::rec_t   out_r, skid_r;
  logic            out_vld_r, skid_vld_r;

  logic            accept;
  logic            drain;
  logic            shift_en;
  logic [7:0]      b;
  logic [31:0]     magic;
  logic            sw_new;
  logic [31:0]     incl;

  assign b      = in_tdata;
  assign accept = in_tvalid && in_tready;
  assign drain  = !out_vld_r || out_tready;

  // Header shift line: oldest byte at index 0
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < psd_pkg::HDR_DEPTH - 1; i++) begin
        hdr_r[i] <= hdr_r[i+1];
      end
      hdr_r[psd_pkg::HDR_DEPTH-1] <= b;
    end
  end

  // Global magic, with the final byte still on the input
  assign magic  = {hdr_r[3], hdr_r[2], hdr_r[1], hdr_r[0]};
  assign sw_new = (magic != psd_pkg::MAGIC_NATIVE);
  assign incl   = psd_pkg::fld32(hdr_r[psd_pkg::PKT_BASE+8], hdr_r[psd_pkg::PKT_BASE+9],
                                 hdr_r[psd_pkg::PKT_BASE+10], hdr_r[psd_pkg::PKT_BASE+11],
                                 swap_r);

  // Parser next state and result
  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    swap_nxt   = swap_r;
    remain_nxt = remain_r;
    shift_en   = 1'b0;
    res_vld    = 1'b0;
    res        = '0;
    res.swapped = swap_r;

    unique case (phase_r)
      psd_pkg::PH_PAYLOAD: begin
        res.kind         = psd_pkg::REC_PAYLOAD;
        res.payload_byte = b;
        res.last         = (remain_r <= 32'd1);
        if (accept) begin
          res_vld = 1'b1;
          if (remain_r <= 32'd1) begin
            remain_nxt = '0;
            phase_nxt  = psd_pkg::PH_PACKET;
            count_nxt  = '0;
          end else begin
            remain_nxt = remain_r - 32'd1;
          end
        end
      end

      psd_pkg::PH_GLOBAL: begin
        res.kind      = psd_pkg::REC_GLOBAL;
        res.swapped   = sw_new;
        res.ver_major = psd_pkg::fld16(hdr_r[4], hdr_r[5], sw_new);
        res.ver_minor = psd_pkg::fld16(hdr_r[6], hdr_r[7], sw_new);
        res.word_a    = magic;
        res.word_b = psd_pkg::fld32(hdr_r[8], hdr_r[9], hdr_r[10], hdr_r[11], sw_new);
        res.word_c = psd_pkg::fld32(hdr_r[12], hdr_r[13], hdr_r[14], hdr_r[15], sw_new);
        res.word_d = psd_pkg::fld32(hdr_r[16], hdr_r[17], hdr_r[18], hdr_r[19], sw_new);
        res.word_e = psd_pkg::fld32(hdr_r[20], hdr_r[21], hdr_r[22], b, sw_new);
        if (accept) begin
          shift_en = 1'b1;
          if (count_r == 5'(psd_pkg::GLOBAL_LEN - 1)) begin
            res_vld   = 1'b1;
            swap_nxt  = sw_new;
            count_nxt = '0;
            phase_nxt = psd_pkg::PH_PACKET;
          end else begin
            count_nxt = count_r + 5'd1;
          end
        end
      end

      // Packet header phase; the unused code behaves the same
      default: begin
        res.kind   = psd_pkg::REC_PACKET;
        res.word_a = psd_pkg::fld32(hdr_r[psd_pkg::PKT_BASE+0], hdr_r[psd_pkg::PKT_BASE+1],
                                    hdr_r[psd_pkg::PKT_BASE+2], hdr_r[psd_pkg::PKT_BASE+3],
                                    swap_r);
        res.word_b = psd_pkg::fld32(hdr_r[psd_pkg::PKT_BASE+4], hdr_r[psd_pkg::PKT_BASE+5],
                                    hdr_r[psd_pkg::PKT_BASE+6], hdr_r[psd_pkg::PKT_BASE+7],
                                    swap_r);
        res.word_c = incl;
        res.word_d = psd_pkg::fld32(hdr_r[psd_pkg::PKT_BASE+12],
                                    hdr_r[psd_pkg::PKT_BASE+13],
                                    hdr_r[psd_pkg::PKT_BASE+14], b, swap_r);
        if (accept) begin
          shift_en = 1'b1;
          if (count_r == 5'(psd_pkg::PACKET_LEN - 1)) begin
            res_vld   = 1'b1;
            count_nxt = '0;
            if (incl == 32'd0) begin
              remain_nxt = '0;
              phase_nxt  = psd_pkg::PH_PACKET;
            end else begin
              remain_nxt = incl;
              phase_nxt  = psd_pkg::PH_PAYLOAD;
            end
          end else begin
            count_nxt = count_r + 5'd1;
            phase_nxt = psd_pkg::PH_PACKET;
          end
        end
      end
    endcase
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= psd_pkg::PH_GLOBAL;
      count_r  <= '0;
      swap_r   <= 1'b0;
      remain_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      swap_r   <= swap_nxt;
      remain_r <= remain_nxt;
    end
  end

  // Output register with skid word; input is blocked only while skid is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (drain) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= res_vld;
      end
    end else if (res_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_r <= skid_vld_r ? skid_r : res;
    end else if (res_vld) begin
      skid_r <= res;
    end
  end

  assign in_tready  = !skid_vld_r;
  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_r.last;
  assign out_tuser  = {out_r.swapped, out_r.kind};
  assign out_tdata  = {out_r.payload_byte, out_r.word_e, out_r.word_d, out_r.word_c,
                       out_r.word_b, out_r.word_a, out_r.ver_minor,
                       out_r.ver_major};

endmodule

`default_nettype wire
